[src/level_crossing_merge_tree_assert.svh]
// Assertion macros for the level crossing merge tree.
// Each macro expects clk and rst in scope.
`ifndef LEVEL_CROSSING_MERGE_TREE_ASSERT_SVH
`define LEVEL_CROSSING_MERGE_TREE_ASSERT_SVH

// same-cycle implication
`define LCMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication
`define LCMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lcmt_pkg.sv]
// ----------------------------------------------------------------------------
// lcmt_pkg
// Shared constants, types and command/status structs of the merge tree.
// ----------------------------------------------------------------------------
package lcmt_pkg;

  localparam int TREE_DEPTH = 6;
  localparam int LEAF_COUNT = 1 << TREE_DEPTH;
  localparam int NODE_COUNT = 2 * LEAF_COUNT - 1;
  localparam int FIRST_LEAF = LEAF_COUNT - 1;
  localparam int NODE_AW    = TREE_DEPTH + 1;
  localparam int MEM_DEPTH  = 1 << NODE_AW;
  localparam int CNT_W      = TREE_DEPTH + 1;

  localparam int CMD_W    = 2;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 7;
  localparam int LEVEL_W  = 18;
  localparam int CLS_W    = 2;
  localparam int XPOS_W   = 7;

  typedef logic [CMD_W-1:0] cmd_code_t;
  localparam cmd_code_t CMD_LOAD  = 2'd0;
  localparam cmd_code_t CMD_EDGE  = 2'd1;
  localparam cmd_code_t CMD_QUERY = 2'd2;

  typedef logic [CLS_W-1:0] cls_t;
  localparam cls_t CLS_NONE = 2'd0;
  localparam cls_t CLS_RISE = 2'd1;
  localparam cls_t CLS_FALL = 2'd2;

  localparam logic [XPOS_W-1:0] XPOS_NONE = '1;
  localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = 18'sd1;

  // write port source select
  typedef logic [1:0] wr_kind_t;
  localparam wr_kind_t WK_LEAF  = 2'd0;
  localparam wr_kind_t WK_EDGE  = 2'd1;
  localparam wr_kind_t WK_SUB   = 2'd2;
  localparam wr_kind_t WK_MERGE = 2'd3;

  typedef struct packed {
    cls_t              cls;
    logic              edg;
    logic              sub;
    logic [XPOS_W-1:0] xpos;
  } node_row_t;

  localparam node_row_t RESET_ROW = '{cls: CLS_NONE, edg: 1'b0, sub: 1'b0, xpos: XPOS_NONE};

  typedef struct packed {
    logic     load_sample;  // sample transfer: count and previous side update
    logic     latch_idx;    // node index transfer: capture node pointer
    logic     rd_merge;     // read both children of the node pointer
    logic     wr_en;
    wr_kind_t wr_kind;
    logic     cur_parent;   // step node pointer to its parent
    logic     cur_dec;      // step node pointer down by one
    logic     merge_start;  // node pointer to last internal node
    logic     out_load;
  } ctrl_t;

  typedef struct packed {
    logic pair_open;     // a sample of this row is already in
    logic row_end;       // next sample closes the last pair
    logic in_idx_ok;     // incoming node index names a node
    logic has_crossing;  // node read on port A is rising or falling
    logic cur_root;      // node pointer is the root
    logic out_free;      // result register can take a new item
  } stat_t;

endpackage

[src/lcmt_in_if.sv]
// ----------------------------------------------------------------------------
// lcmt_in_if
// Command channel: valid/ready with command, sample and node index.
// ----------------------------------------------------------------------------
interface lcmt_in_if import lcmt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic signed [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]           node_index;

  modport source (output valid, cmd, sample, node_index, input ready);
  modport sink (input valid, cmd, sample, node_index, output ready);
endinterface

[src/lcmt_out_if.sv]
// ----------------------------------------------------------------------------
// lcmt_out_if
// Result channel: valid/ready with the fields of one node report.
// ----------------------------------------------------------------------------
interface lcmt_out_if import lcmt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CLS_W-1:0]         root_type;
  logic                     zero_edge;
  logic                     has_zero_subedge;
  logic                     edge_marked;
  logic signed [XPOS_W-1:0] zero_base;

  modport source (output valid, root_type, zero_edge, has_zero_subedge, edge_marked,
                  zero_base, input ready);
  modport sink (input valid, root_type, zero_edge, has_zero_subedge, edge_marked,
                zero_base, output ready);
endinterface

[src/lcmt_ctrl.sv]
// ----------------------------------------------------------------------------
// lcmt_ctrl
// Sequencer: command dispatch, ancestor walk, bottom-up merge, query reply.
// ----------------------------------------------------------------------------
module lcmt_ctrl import lcmt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  stat_t            status,
  output ctrl_t            ctl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERD   = 4'd1;
  localparam logic [3:0] S_EWR   = 4'd2;
  localparam logic [3:0] S_ARD   = 4'd3;
  localparam logic [3:0] S_AWR   = 4'd4;
  localparam logic [3:0] S_MRD   = 4'd5;
  localparam logic [3:0] S_MWR   = 4'd6;
  localparam logic [3:0] S_QRD   = 4'd7;
  localparam logic [3:0] S_QWAIT = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_LOAD: begin
              ctl.load_sample = 1'b1;
              if (status.pair_open) begin
                ctl.wr_en   = 1'b1;
                ctl.wr_kind = WK_LEAF;
              end
              if (status.row_end) begin
                ctl.merge_start = 1'b1;
                state_next      = S_MRD;
              end
            end
            CMD_EDGE: begin
              ctl.latch_idx = 1'b1;
              if (status.in_idx_ok) begin
                state_next = S_ERD;
              end
            end
            CMD_QUERY: begin
              ctl.latch_idx = 1'b1;
              state_next    = S_QRD;
            end
            default: begin
            end
          endcase
        end
      end
      S_ERD: begin
        state_next = S_EWR;
      end
      S_EWR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_kind = WK_EDGE;
        if (status.has_crossing && !status.cur_root) begin
          ctl.cur_parent = 1'b1;
          state_next     = S_ARD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ARD: begin
        state_next = S_AWR;
      end
      S_AWR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_kind = WK_SUB;
        if (status.cur_root) begin
          state_next = S_IDLE;
        end else begin
          ctl.cur_parent = 1'b1;
          state_next     = S_ARD;
        end
      end
      S_MRD: begin
        ctl.rd_merge = 1'b1;
        state_next   = S_MWR;
      end
      S_MWR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_kind = WK_MERGE;
        if (status.cur_root) begin
          state_next = S_IDLE;
        end else begin
          ctl.cur_dec = 1'b1;
          state_next  = S_MRD;
        end
      end
      S_QRD: begin
        state_next = S_QWAIT;
      end
      S_QWAIT: begin
        if (status.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/lcmt_dp.sv]
// ----------------------------------------------------------------------------
// lcmt_dp
// Datapath: level register, row counter, node memory, merge logic, result reg.
// ----------------------------------------------------------------------------
module lcmt_dp import lcmt_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       level_we,
  input  logic signed [LEVEL_W-1:0]  level_wdata,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [IDX_W-1:0]           node_index,
  input  ctrl_t                      ctl,
  output stat_t                      status,
  lcmt_out_if.source                 results
);

  logic signed [LEVEL_W-1:0] level;
  logic [CNT_W-1:0]          count;
  logic                      prev_above;
  logic [NODE_AW-1:0]        cur;
  logic                      cur_ok;

  node_row_t          mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] row_valid;
  node_row_t          rd_a;
  node_row_t          rd_b;
  logic               vld_a;
  logic               vld_b;
  node_row_t          eff_a;
  node_row_t          eff_b;
  logic [NODE_AW-1:0] addr_a;
  logic [NODE_AW-1:0] addr_b;

  logic signed [LEVEL_W-1:0] sample2;
  logic                      above;
  cls_t                      leaf_cls;
  node_row_t                 leaf_row;
  node_row_t                 merge_row;
  node_row_t                 wr_row;
  logic [NODE_AW-1:0]        wr_addr;
  logic [NODE_AW-1:0]        leaf_addr;
  cls_t                      mcls;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_RESET;
    end else if (level_we) begin
      level <= level_wdata;
    end
  end

  // sample times two, compared against the level (equal counts as below)
  assign sample2 = {{(LEVEL_W-SAMPLE_W-1){sample[SAMPLE_W-1]}}, sample, 1'b0};
  assign above   = sample2 > level;

  always_comb begin
    if (prev_above) begin
      leaf_cls = above ? CLS_NONE : CLS_FALL;
    end else begin
      leaf_cls = above ? CLS_RISE : CLS_NONE;
    end
  end

  assign leaf_addr     = NODE_AW'(FIRST_LEAF - 1) + count;
  assign leaf_row.cls  = leaf_cls;
  assign leaf_row.edg  = 1'b0;
  assign leaf_row.sub  = 1'b0;
  assign leaf_row.xpos = (leaf_cls != CLS_NONE) ? XPOS_W'(count - 1'b1) : XPOS_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      prev_above <= 1'b0;
    end else if (ctl.load_sample) begin
      prev_above <= above;
      if (count == '0) begin
        count <= CNT_W'(1);
      end else if (count == CNT_W'(LEAF_COUNT)) begin
        count <= '0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_idx) begin
      cur    <= NODE_AW'(node_index);
      cur_ok <= 32'(node_index) < NODE_COUNT;
    end else if (ctl.merge_start) begin
      cur <= NODE_AW'(FIRST_LEAF - 1);
    end else if (ctl.cur_parent) begin
      cur <= NODE_AW'(cur - 1'b1) >> 1;
    end else if (ctl.cur_dec) begin
      cur <= cur - 1'b1;
    end
  end

  // node memory, two registered read ports
  assign addr_a = ctl.rd_merge ? NODE_AW'({cur, 1'b1}) : cur;
  assign addr_b = NODE_AW'({cur, 1'b0}) + NODE_AW'(2);

  always_ff @(posedge clk) begin
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // rows never written since reset read as the reset row
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      vld_a     <= 1'b0;
      vld_b     <= 1'b0;
    end else begin
      vld_a <= row_valid[addr_a];
      vld_b <= row_valid[addr_b];
      if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign eff_a = vld_a ? rd_a : RESET_ROW;
  assign eff_b = vld_b ? rd_b : RESET_ROW;

  // parent from two children
  assign mcls          = eff_a.cls | eff_b.cls;
  assign merge_row.cls = mcls;
  assign merge_row.edg = 1'b0;
  assign merge_row.sub = 1'b0;
  always_comb begin
    if (mcls == CLS_RISE || mcls == CLS_FALL) begin
      merge_row.xpos = (eff_a.cls == mcls) ? eff_a.xpos : eff_b.xpos;
    end else begin
      merge_row.xpos = XPOS_NONE;
    end
  end

  always_comb begin
    wr_addr = cur;
    wr_row  = eff_a;
    case (ctl.wr_kind)
      WK_LEAF: begin
        wr_addr = leaf_addr;
        wr_row  = leaf_row;
      end
      WK_EDGE: begin
        wr_row.edg = 1'b1;
      end
      WK_SUB: begin
        wr_row.sub = 1'b1;
      end
      WK_MERGE: begin
        wr_row = merge_row;
      end
      default: begin
      end
    endcase
  end

  // result register
  node_row_t q_row;
  assign q_row = cur_ok ? eff_a : RESET_ROW;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (ctl.out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      results.root_type        <= q_row.cls;
      results.zero_edge        <= q_row.edg && !q_row.sub &&
                                  (q_row.cls == CLS_RISE || q_row.cls == CLS_FALL);
      results.has_zero_subedge <= q_row.sub;
      results.edge_marked      <= q_row.edg;
      results.zero_base        <= q_row.xpos;
    end
  end

  assign status.pair_open    = count != '0;
  assign status.row_end      = count == CNT_W'(LEAF_COUNT);
  assign status.in_idx_ok    = 32'(node_index) < NODE_COUNT;
  assign status.has_crossing = eff_a.cls == CLS_RISE || eff_a.cls == CLS_FALL;
  assign status.cur_root     = cur == '0;
  assign status.out_free     = !results.valid || results.ready;

endmodule

[src/level_crossing_merge_tree.sv]
// ----------------------------------------------------------------------------
// level_crossing_merge_tree
// Row level-crossing classifier with a binary merge tree of crossings.
// ----------------------------------------------------------------------------
// Usage:
//   items   : command channel (valid/ready). cmd 0 loads the next sample of
//             a row of LEAF_COUNT+1 samples, cmd 1 marks node_index as an
//             edge, cmd 2 queries node_index. cmd 3 is taken and dropped.
//   results : one node report per query, held in an output register.
//   level   : threshold, written through level_we/level_wdata while idle.
// Work per transfer on items, one node memory port pair being the limit:
//   sample                taken without leaving idle; the row's last sample adds the
//                         bottom-up merge, a read and a write state per internal node
//   mark edge             node read and write; on a crossing, the same per ancestor
//   query                 node read, then a wait until the result register is free;
//                         the result then shows on results from that register
// A query waits in place while the result register is still full, so a
// stalled receiver holds off the command channel after one buffered result.
// Reset: synchronous; level goes to 1, the row counter clears, and every node
// reads as empty (class none, no flags, no crossing) through per-row valid
// bits, so there is no clearing pass and the block is ready at once.
// ----------------------------------------------------------------------------
module level_crossing_merge_tree import lcmt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      level_we,
  input  logic signed [LEVEL_W-1:0] level_wdata,
  lcmt_in_if.sink                   items,
  lcmt_out_if.source                results
);

  ctrl_t ctl;
  stat_t status;

  // sequencer: owns the command channel handshake
  lcmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_cmd   (items.cmd),
    .in_ready (items.ready),
    .status   (status),
    .ctl      (ctl)
  );

  // storage and arithmetic: owns the result channel
  lcmt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .level_we    (level_we),
    .level_wdata (level_wdata),
    .sample      (items.sample),
    .node_index  (items.node_index),
    .ctl         (ctl),
    .status      (status),
    .results     (results)
  );

`include "level_crossing_merge_tree_assert.svh"

  // a query taken with an empty result register is reported on results
  `LCMT_ASSERT_IMPL(a_query_latency, items.valid && items.ready && items.cmd == CMD_QUERY && !results.valid, ##3 results.valid, "query result missing")

  // the merge never overlaps a new transfer
  `LCMT_ASSERT_IMPL(a_merge_busy, ctl.wr_en && ctl.wr_kind == WK_MERGE, !items.ready, "transfer during merge")

  // the sample closing a row starts the merge next cycle
  `LCMT_ASSERT_NEXT(a_row_end_merge, ctl.load_sample && status.row_end, !items.ready && ctl.rd_merge, "row end without merge")

endmodule

[verif/tb_level_crossing_merge_tree.sv]
// ----------------------------------------------------------------------------
// tb_level_crossing_merge_tree
// Self-checking bench for the row crossing classifier and its merge tree.
// A short table of directed commands is sent first, then rows of samples mixed
// with edge marks, node queries and dropped commands, under several level
// settings and pacing modes. Every node report is checked field by field
// against the table's expected report or an in-bench model of the tree.
// ----------------------------------------------------------------------------
module tb_level_crossing_merge_tree;
  import lcmt_pkg::*;

  // command 3 is taken by the block and dropped
  localparam cmd_code_t CMD_NOP  = 2'd3;

  localparam int SETTLE_CYCLES  = 300;   // longer than a full-row merge plus an edge walk
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transfer
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int PLAN_LEN       = 20;
  localparam int PHASES         = 7;
  localparam int PRESSURE_PHASE = 4;

  typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH_LIGHT} pace_t;

  // one node report
  typedef struct packed {
    cls_t              kind;
    logic              zero_edge;
    logic              subedge;
    logic              marked;
    logic [XPOS_W-1:0] base;
  } report_t;

  localparam report_t EMPTY_REPORT =
    '{kind: CLS_NONE, zero_edge: 1'b0, subedge: 1'b0, marked: 1'b0, base: XPOS_NONE};

  // directed command; want is used only where typed is set
  typedef struct packed {
    cmd_code_t           cmd;
    logic [SAMPLE_W-1:0] smp;
    logic [IDX_W-1:0]    idx;
    logic                typed;
    report_t             want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic level_we;
  logic signed [LEVEL_W-1:0] level_wdata;

  lcmt_in_if  items_if ();
  lcmt_out_if results_if ();

  level_crossing_merge_tree DUT (
    .clk         (clk),
    .rst         (rst),
    .level_we    (level_we),
    .level_wdata (level_wdata),
    .items       (items_if),
    .results     (results_if)
  );

  // --------------------------------------------------------------------------
  // Tree model: class, mark, subedge flag and crossing position per node,
  // plus the row fill count, the side of the last sample and the level.
  // --------------------------------------------------------------------------
  cls_t              node_kind [NODE_COUNT];
  logic              node_mark [NODE_COUNT];
  logic              node_sub  [NODE_COUNT];
  logic [XPOS_W-1:0] node_xpos [NODE_COUNT];
  int                row_fill;
  logic              prev_high;
  logic signed [LEVEL_W-1:0] level_now;

  report_t pending_reports [$];

  int fail_count;
  int n_items;
  int n_reports;
  int n_rows;
  int n_levels;
  int send_gap_pct;
  int stall_pct;
  int hold_left;

  // Applies one accepted command to the model; a query yields a report.
  task automatic tree_apply(input cmd_code_t cmd, input logic signed [SAMPLE_W-1:0] smp,
                            input logic [IDX_W-1:0] idx, output bit makes,
                            output report_t rep);
    logic high;
    int   leaf;
    int   n;
    cls_t c;
    makes = 1'b0;
    rep   = EMPTY_REPORT;
    case (cmd)
      CMD_LOAD: begin
        // equal to the level counts as below
        high = (2 * int'(smp) > int'(level_now));
        if (row_fill == 0) begin
          row_fill = 1;
        end else begin
          leaf = FIRST_LEAF + row_fill - 1;
          c = prev_high ? (high ? CLS_NONE : CLS_FALL) : (high ? CLS_RISE : CLS_NONE);
          node_kind[leaf] = c;
          node_mark[leaf] = 1'b0;
          node_sub[leaf]  = 1'b0;
          node_xpos[leaf] = (c != CLS_NONE) ? XPOS_W'(row_fill - 1) : XPOS_NONE;
          row_fill++;
          if (row_fill >= LEAF_COUNT + 1) begin
            // bottom-up merge of all internal nodes
            for (int k = FIRST_LEAF - 1; k >= 0; k--) begin
              c = node_kind[2*k+1] | node_kind[2*k+2];
              node_kind[k] = c;
              node_mark[k] = 1'b0;
              node_sub[k]  = 1'b0;
              if (c == CLS_RISE || c == CLS_FALL)
                node_xpos[k] = (node_kind[2*k+1] == c) ? node_xpos[2*k+1] : node_xpos[2*k+2];
              else
                node_xpos[k] = XPOS_NONE;
            end
            row_fill = 0;
            n_rows++;
          end
        end
        prev_high = high;
      end
      CMD_EDGE: begin
        if (idx < NODE_COUNT) begin
          node_mark[idx] = 1'b1;
          if (node_xpos[idx] != XPOS_NONE) begin
            n = idx;
            while (n > 0) begin
              n = (n - 1) / 2;
              node_sub[n] = 1'b1;
            end
          end
        end
      end
      CMD_QUERY: begin
        makes = 1'b1;
        if (idx < NODE_COUNT) begin
          c = node_kind[idx];
          rep.kind      = c;
          rep.zero_edge = node_mark[idx] && !node_sub[idx] && (c == CLS_RISE || c == CLS_FALL);
          rep.subedge   = node_sub[idx];
          rep.marked    = node_mark[idx];
          rep.base      = node_xpos[idx];
        end
      end
      default: ;  // dropped
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Ends the run when neither channel has moved a transfer for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer in %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: checks each transfer against the oldest expected report,
  // then sets ready for the next cycle (random stalls, or a counted hold).
  // --------------------------------------------------------------------------
  task automatic compare_report();
    report_t want;
    if (pending_reports.size() == 0) begin
      $error("unexpected report: root_type %0d zero_base %0d",
             results_if.root_type, results_if.zero_base);
      fail_count++;
    end else begin
      want = pending_reports.pop_front();
      n_reports++;
      if (results_if.root_type !== want.kind) begin
        $error("root_type: expected %0d, got %0d", want.kind, results_if.root_type);
        fail_count++;
      end
      if (results_if.zero_edge !== want.zero_edge) begin
        $error("zero_edge: expected %0d, got %0d", want.zero_edge, results_if.zero_edge);
        fail_count++;
      end
      if (results_if.has_zero_subedge !== want.subedge) begin
        $error("has_zero_subedge: expected %0d, got %0d", want.subedge,
               results_if.has_zero_subedge);
        fail_count++;
      end
      if (results_if.edge_marked !== want.marked) begin
        $error("edge_marked: expected %0d, got %0d", want.marked, results_if.edge_marked);
        fail_count++;
      end
      if (results_if.zero_base !== want.base) begin
        $error("zero_base: expected %0d, got %0d", $signed(want.base), results_if.zero_base);
        fail_count++;
      end
    end
  endtask

  initial begin
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_if.valid && results_if.ready)
        compare_report();
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Offers one command (after random idle cycles) and waits for its transfer.
  // Entered and left right after a rising edge.
  task automatic send_item(input cmd_code_t cmd, input logic [SAMPLE_W-1:0] smp,
                           input logic [IDX_W-1:0] idx, input bit typed,
                           input report_t want);
    bit      makes;
    report_t rep;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid      <= 1'b1;
    items_if.cmd        <= cmd;
    items_if.sample     <= smp;
    items_if.node_index <= idx;
    do @(posedge clk); while (!items_if.ready);
    tree_apply(cmd, smp, idx, makes, rep);
    if (makes)
      pending_reports.push_back(typed ? want : rep);
  endtask

  // Stops offering and waits for every outstanding report.
  task automatic drain_reports();
    items_if.valid <= 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
  endtask

  // Reports done; extra cycles cover a merge or ancestor walk still running.
  task automatic settle_block();
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_level(input logic signed [LEVEL_W-1:0] value);
    level_we    <= 1'b1;
    level_wdata <= value;
    @(posedge clk);
    level_we  <= 1'b0;
    level_now = value;
    n_levels++;
  endtask

  // Sample on the requested side of the level; often right at the boundary.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input bit high);
    int half;
    int lo;
    int hi;
    half = int'(level_now) >>> 1;   // above  <=>  s > floor(level/2)
    lo = high ? half + 1 : -32768;
    hi = high ? 32767 : half;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    if (lo > hi || $urandom_range(0, 7) == 0)
      return SAMPLE_W'($urandom);
    case ($urandom_range(0, 7))
      0:       return SAMPLE_W'(high ? lo : hi);
      1:       return SAMPLE_W'(high ? hi : lo);
      default: return SAMPLE_W'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  // Mostly internal nodes, where merges and subedge flags live.
  function automatic logic [IDX_W-1:0] pick_node();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return IDX_W'($urandom_range(0, FIRST_LEAF - 1));
      4, 5, 6:    return IDX_W'($urandom_range(FIRST_LEAF, NODE_COUNT - 1));
      default:    return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    endcase
  endfunction

  function automatic void set_pace(input pace_t pace);
    send_gap_pct = (pace == PACE_SEND_GAPS) ? 80 : (pace == PACE_BOTH_LIGHT) ? 8 : 0;
    stall_pct    = (pace == PACE_RECV_STALLS) ? 80 : (pace == PACE_BOTH_LIGHT) ? 8 : 0;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: reset contents, sample extremes, a rising and a falling
  // pair, a query in the middle of a row, a mark with and without a crossing,
  // a mark on a leaf not closed yet, the out-of-range node and command 3.
  // --------------------------------------------------------------------------
  plan_row_t plan [PLAN_LEN];

  initial begin
    plan = '{
      '{CMD_QUERY, 16'h0000, 7'd0,   1'b1, EMPTY_REPORT},  // root after reset
      '{CMD_QUERY, 16'h0000, 7'd127, 1'b1, EMPTY_REPORT},  // beyond the tree
      '{CMD_QUERY, 16'h0000, 7'd126, 1'b1, EMPTY_REPORT},  // last leaf after reset
      '{CMD_NOP,   16'hFFFF, 7'd5,   1'b0, EMPTY_REPORT},  // dropped, no report
      '{CMD_EDGE,  16'h0000, 7'd127, 1'b0, EMPTY_REPORT},  // mark beyond tree: ignored
      '{CMD_LOAD,  16'h8000, 7'd0,   1'b0, EMPTY_REPORT},  // row start, most negative
      '{CMD_LOAD,  16'h7FFF, 7'd0,   1'b0, EMPTY_REPORT},  // rising, pair 0
      '{CMD_QUERY, 16'h0000, 7'd63,  1'b0, EMPTY_REPORT},
      '{CMD_LOAD,  16'h0000, 7'd0,   1'b0, EMPTY_REPORT},  // falling, pair 1
      '{CMD_LOAD,  16'h0001, 7'd0,   1'b0, EMPTY_REPORT},  // 2 > 1: rising, pair 2
      '{CMD_QUERY, 16'h0000, 7'd64,  1'b0, EMPTY_REPORT},
      '{CMD_QUERY, 16'h0000, 7'd65,  1'b0, EMPTY_REPORT},
      '{CMD_EDGE,  16'h0000, 7'd63,  1'b0, EMPTY_REPORT},  // crossing: flags ancestors
      '{CMD_QUERY, 16'h0000, 7'd63,  1'b0, EMPTY_REPORT},
      '{CMD_QUERY, 16'h0000, 7'd31,  1'b0, EMPTY_REPORT},  // parent, not merged yet
      '{CMD_QUERY, 16'h0000, 7'd0,   1'b0, EMPTY_REPORT},
      '{CMD_EDGE,  16'h0000, 7'd0,   1'b0, EMPTY_REPORT},  // root, no crossing
      '{CMD_QUERY, 16'h0000, 7'd0,   1'b0, EMPTY_REPORT},
      '{CMD_EDGE,  16'h0000, 7'd66,  1'b0, EMPTY_REPORT},  // leaf not closed yet
      '{CMD_QUERY, 16'h0000, 7'd127, 1'b1, EMPTY_REPORT}   // still empty
    };
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int        phase_items [PHASES];
    pace_t     phase_pace  [PHASES];
    logic signed [LEVEL_W-1:0] next_level;
    int        sent;
    bit        paused;
    bit        counted;
    bit        gen_high;
    int        flip_pct;
    int        pick;
    cmd_code_t cmd;
    logic [SAMPLE_W-1:0] smp;
    logic [IDX_W-1:0]    idx;

    phase_items = '{80, 80, 40, 40, 90, 90, 80};
    phase_pace  = '{PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH_LIGHT,
                    PACE_FULL, PACE_RECV_STALLS, PACE_BOTH_LIGHT};

    // model reset state
    for (int k = 0; k < NODE_COUNT; k++) begin
      node_kind[k] = CLS_NONE;
      node_mark[k] = 1'b0;
      node_sub[k]  = 1'b0;
      node_xpos[k] = XPOS_NONE;
    end
    row_fill   = 0;
    prev_high  = 1'b0;
    level_now  = LEVEL_RESET;
    fail_count = 0;
    n_items    = 0;
    n_reports  = 0;
    n_rows     = 0;
    n_levels   = 0;
    hold_left  = 0;
    gen_high   = 1'b0;
    flip_pct   = 50;
    set_pace(PACE_FULL);

    rst                 <= 1'b1;
    level_we            <= 1'b0;
    level_wdata         <= '0;
    items_if.valid      <= 1'b0;
    items_if.cmd        <= CMD_LOAD;
    items_if.sample     <= '0;
    items_if.node_index <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      send_item(plan[i].cmd, plan[i].smp, plan[i].idx, plan[i].typed, plan[i].want);
      n_items++;
    end

    // Random phases. Phase 0 keeps the reset level; later phases write the
    // level while the block is idle: zero, both extremes, random values.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle_block();
        case (p)
          1:       next_level = '0;
          2:       next_level = 18'sh1FFFF;    // nothing is above
          3:       next_level = -18'sh20000;   // everything is above
          4:       next_level = LEVEL_W'($urandom_range(0, 2000) - 1000);
          5:       next_level = LEVEL_W'($urandom);
          default: next_level = LEVEL_W'($urandom_range(0, 64) - 32);
        endcase
        set_level(next_level);
      end
      set_pace(phase_pace[p]);
      sent   = 0;
      paused = 1'b0;

      // Receiver holds off while queries keep coming: the result register
      // fills and the block must stall the command channel.
      if (p == PRESSURE_PHASE) begin
        hold_left = HOLD_CYCLES;
        repeat (12) begin
          send_item(CMD_QUERY, SAMPLE_W'($urandom), pick_node(), 1'b0, EMPTY_REPORT);
          sent++;
        end
      end

      while (sent < phase_items[p]) begin
        // sender pause halfway: everything outstanding must come back
        if (!paused && sent >= phase_items[p] / 2) begin
          drain_reports();
          @(posedge clk);
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        cmd  = (pick < 55) ? CMD_LOAD : (pick < 70) ? CMD_EDGE :
               (pick < 95) ? CMD_QUERY : CMD_NOP;
        idx  = pick_node();
        if (cmd == CMD_LOAD) begin
          // each row is either sparse (few crossings) or dense
          if (row_fill == 0)
            flip_pct = $urandom_range(0, 1) ? 50 : 6;
          if ($urandom_range(0, 99) < flip_pct)
            gen_high = !gen_high;
          smp = pick_sample(gen_high);
        end else begin
          smp = SAMPLE_W'($urandom);
        end
        counted = !(cmd == CMD_NOP || (cmd == CMD_EDGE && idx >= NODE_COUNT));
        send_item(cmd, smp, idx, 1'b0, EMPTY_REPORT);
        if (counted) begin
          sent++;
          n_items++;
        end
      end
    end

    settle_block();
    $display("covered %0d commands, %0d node reports checked, %0d rows merged",
             n_items, n_reports, n_rows);
    $display("level written %0d times, %0d phases of pacing", n_levels, PHASES);
    if (fail_count == 0 && pending_reports.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[level_crossing_merge_tree.f]
+incdir+src
src/lcmt_pkg.sv
src/lcmt_in_if.sv
src/lcmt_out_if.sv
src/lcmt_ctrl.sv
src/lcmt_dp.sv
src/level_crossing_merge_tree.sv
verif/tb_level_crossing_merge_tree.sv
